>>> sv/lrbs_pkg.sv
`default_nettype none
package lrbs_pkg;

  localparam int unsigned MAX_KNOWN = 16;

  // Supervisor modes
  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_SCAN  = 3'd1;
  localparam logic [2:0] MODE_CONN  = 3'd2;
  localparam logic [2:0] MODE_UP    = 3'd3;
  localparam logic [2:0] MODE_RETRY = 3'd4;

  // Request types
  localparam logic [1:0] REQ_TICK      = 2'd0;
  localparam logic [1:0] REQ_SCAN_ENT  = 2'd1;
  localparam logic [1:0] REQ_SCAN_END  = 2'd2;
  localparam logic [1:0] REQ_RECONNECT = 2'd3;

  // Commands
  localparam logic [1:0] CMD_NONE    = 2'd0;
  localparam logic [1:0] CMD_SCAN    = 2'd1;
  localparam logic [1:0] CMD_CONNECT = 2'd2;
  localparam logic [1:0] CMD_DROP    = 2'd3;

  // Indicator actions
  localparam logic [1:0] IND_NONE = 2'd0;
  localparam logic [1:0] IND_ON   = 2'd1;
  localparam logic [1:0] IND_OFF  = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_CONNECT_TIMEOUT = 3'd0;
  localparam logic [2:0] REG_RETRY_LIMIT     = 3'd1;
  localparam logic [2:0] REG_BASE_DELAY      = 3'd2;
  localparam logic [2:0] REG_MAX_DELAY       = 3'd3;
  localparam logic [2:0] REG_DROP_DELAY      = 3'd4;
  localparam logic [2:0] REG_KNOWN_COUNT     = 3'd5;

  // Register reset values
  localparam logic [15:0] RST_CONNECT_TIMEOUT = 16'd12000;
  localparam logic [3:0]  RST_RETRY_LIMIT     = 4'd5;
  localparam logic [15:0] RST_BASE_DELAY      = 16'd2000;
  localparam logic [15:0] RST_MAX_DELAY       = 16'd30000;
  localparam logic [15:0] RST_DROP_DELAY      = 16'd4000;
  localparam logic [4:0]  RST_KNOWN_COUNT     = 5'd0;

  localparam logic [15:0] TICKS_MAX = 16'hFFFF;

endpackage
`default_nettype wire

>>> sv/link_reconnect_backoff_supervisor.sv
`default_nettype none
// Link reconnect supervisor with exponential retry backoff. Each input transfer is one event:
// a 1 ms tick with link status, a scan entry, a scan end or a reconnect request, and each
// yields exactly one result transfer (mode after the event, link command, network index,
// timeout count, connected flag, indicator action). Throughput is one event per clock: the
// whole state update is a single pass of compare/add logic from the input port into the
// state registers and a one-entry output register, and the input stalls only while that
// output register is full and the consumer stalls it. After reset the block is idle until a
// reconnect request arrives. The user writes registers over the cfg port (always ready) only
// while no event is in flight; the block does not enforce it. Indexes 6 and 7 are ignored.
module link_reconnect_backoff_supervisor (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration write channel
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [2:0]        cfg_index_i,
  input  wire logic [15:0]       cfg_data_i,
  // event channel
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        req_type_i,
  input  wire logic              link_up_i,
  input  wire logic              scan_match_i,
  input  wire logic [3:0]        scan_known_index_i,
  input  wire logic signed [7:0] scan_rssi_i,
  // result channel
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [2:0]             fsm_state_o,
  output logic [1:0]             command_o,
  output logic [3:0]             connect_index_o,
  output logic [3:0]             retry_count_o,
  output logic                   connected_o,
  output logic [1:0]             indicator_o
);

  // configuration registers
  logic [15:0] connect_timeout_q, base_delay_q, max_delay_q, drop_delay_q;
  logic [3:0]  retry_limit_q;
  logic [4:0]  known_count_q;

  // supervisor state
  logic [2:0]        mode_q, mode_d;
  logic [15:0]       elapsed_q, elapsed_d;
  logic [15:0]       backoff_q, backoff_d;
  logic [3:0]        timeouts_q, timeouts_d;
  logic [3:0]        cur_index_q, cur_index_d;
  logic              scanning_q, scanning_d;
  logic              best_valid_q, best_valid_d;
  logic [3:0]        best_index_q, best_index_d;
  logic signed [7:0] best_level_q, best_level_d;
  logic              last_link_q, last_link_d;

  // result register
  logic       out_valid_q;
  logic [2:0] res_state_q;
  logic [1:0] res_cmd_q, res_cmd_d;
  logic [3:0] res_index_q, res_index_d;
  logic [3:0] res_retry_q;
  logic       res_conn_q;
  logic [1:0] res_ind_q, res_ind_d;

  logic        in_fire;
  logic [4:0]  known_limit;
  logic [15:0] tick_elapsed;
  logic [16:0] doubled;
  logic [15:0] grown;
  logic [3:0]  timeouts_inc;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_fire     = in_valid_i & ~in_stall_o;

  // Clamp the known-network count to the table size.
  assign known_limit = (known_count_q < 5'(lrbs_pkg::MAX_KNOWN))
                       ? known_count_q : 5'(lrbs_pkg::MAX_KNOWN);

  // Saturating timer advance for a tick.
  assign tick_elapsed = (elapsed_q < lrbs_pkg::TICKS_MAX) ? elapsed_q + 16'd1 : elapsed_q;

  // Doubled backoff, capped at the configured maximum.
  assign doubled = {backoff_q, 1'b0};
  assign grown   = (doubled < {1'b0, max_delay_q}) ? doubled[15:0] : max_delay_q;

  assign timeouts_inc = timeouts_q + 4'd1;

  always_comb begin
    mode_d       = mode_q;
    elapsed_d    = elapsed_q;
    backoff_d    = backoff_q;
    timeouts_d   = timeouts_q;
    cur_index_d  = cur_index_q;
    scanning_d   = scanning_q;
    best_valid_d = best_valid_q;
    best_index_d = best_index_q;
    best_level_d = best_level_q;
    last_link_d  = last_link_q;
    res_cmd_d    = lrbs_pkg::CMD_NONE;
    res_ind_d    = lrbs_pkg::IND_NONE;
    res_index_d  = cur_index_q;

    case (req_type_i)
      lrbs_pkg::REQ_TICK: begin
        elapsed_d   = tick_elapsed;
        last_link_d = link_up_i;
        case (mode_q)
          lrbs_pkg::MODE_SCAN: begin
            // open the scan on the first tick after entering scanning
            if (!scanning_q) begin
              scanning_d   = 1'b1;
              best_valid_d = 1'b0;
              res_cmd_d    = lrbs_pkg::CMD_SCAN;
            end
          end
          lrbs_pkg::MODE_CONN: begin
            if (link_up_i) begin
              mode_d     = lrbs_pkg::MODE_UP;
              elapsed_d  = '0;
              timeouts_d = '0;
              backoff_d  = base_delay_q;
              res_ind_d  = lrbs_pkg::IND_ON;
            end else if (tick_elapsed > connect_timeout_q) begin
              res_cmd_d = lrbs_pkg::CMD_DROP;
              elapsed_d = '0;
              if (timeouts_inc >= retry_limit_q) begin
                // give up on this network and rescan
                timeouts_d = '0;
                backoff_d  = base_delay_q;
                mode_d     = lrbs_pkg::MODE_SCAN;
                scanning_d = 1'b0;
              end else begin
                timeouts_d = timeouts_inc;
                mode_d     = lrbs_pkg::MODE_RETRY;
                backoff_d  = grown;
              end
            end
          end
          lrbs_pkg::MODE_UP: begin
            if (!link_up_i) begin
              res_ind_d  = lrbs_pkg::IND_OFF;
              timeouts_d = '0;
              backoff_d  = drop_delay_q;
              mode_d     = lrbs_pkg::MODE_RETRY;
              elapsed_d  = '0;
            end
          end
          lrbs_pkg::MODE_RETRY: begin
            if (tick_elapsed >= backoff_q) begin
              mode_d     = lrbs_pkg::MODE_SCAN;
              elapsed_d  = '0;
              scanning_d = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      lrbs_pkg::REQ_SCAN_ENT: begin
        // keep the strongest match; ties keep the earlier entry
        if (mode_q == lrbs_pkg::MODE_SCAN && scanning_q && scan_match_i &&
            ({1'b0, scan_known_index_i} < known_limit)) begin
          if (!best_valid_q || (scan_rssi_i > best_level_q)) begin
            best_valid_d = 1'b1;
            best_index_d = scan_known_index_i;
            best_level_d = scan_rssi_i;
          end
        end
      end
      lrbs_pkg::REQ_SCAN_END: begin
        if (mode_q == lrbs_pkg::MODE_SCAN && scanning_q) begin
          scanning_d   = 1'b0;
          best_valid_d = 1'b0;
          elapsed_d    = '0;
          if (best_valid_q) begin
            if ({1'b0, best_index_q} < known_limit) begin
              cur_index_d = best_index_q;
              mode_d      = lrbs_pkg::MODE_CONN;
              res_cmd_d   = lrbs_pkg::CMD_CONNECT;
              res_index_d = best_index_q;
            end else begin
              // known list shrank under the chosen entry
              mode_d = lrbs_pkg::MODE_IDLE;
            end
          end else begin
            mode_d    = lrbs_pkg::MODE_RETRY;
            backoff_d = grown;
          end
        end
      end
      default: begin
        // reconnect request: drop and rescan from any mode
        res_cmd_d    = lrbs_pkg::CMD_DROP;
        mode_d       = lrbs_pkg::MODE_SCAN;
        elapsed_d    = '0;
        scanning_d   = 1'b0;
        best_valid_d = 1'b0;
        timeouts_d   = '0;
        backoff_d    = base_delay_q;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      connect_timeout_q <= lrbs_pkg::RST_CONNECT_TIMEOUT;
      retry_limit_q     <= lrbs_pkg::RST_RETRY_LIMIT;
      base_delay_q      <= lrbs_pkg::RST_BASE_DELAY;
      max_delay_q       <= lrbs_pkg::RST_MAX_DELAY;
      drop_delay_q      <= lrbs_pkg::RST_DROP_DELAY;
      known_count_q     <= lrbs_pkg::RST_KNOWN_COUNT;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        lrbs_pkg::REG_CONNECT_TIMEOUT: connect_timeout_q <= cfg_data_i;
        lrbs_pkg::REG_RETRY_LIMIT:     retry_limit_q     <= cfg_data_i[3:0];
        lrbs_pkg::REG_BASE_DELAY:      base_delay_q      <= cfg_data_i;
        lrbs_pkg::REG_MAX_DELAY:       max_delay_q       <= cfg_data_i;
        lrbs_pkg::REG_DROP_DELAY:      drop_delay_q      <= cfg_data_i;
        lrbs_pkg::REG_KNOWN_COUNT:     known_count_q     <= cfg_data_i[4:0];
        default: begin
        end
      endcase
    end
  end

  // state update on each accepted event
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= lrbs_pkg::MODE_IDLE;
      elapsed_q    <= '0;
      backoff_q    <= lrbs_pkg::RST_BASE_DELAY;
      timeouts_q   <= '0;
      cur_index_q  <= '0;
      scanning_q   <= 1'b0;
      best_valid_q <= 1'b0;
      best_index_q <= '0;
      best_level_q <= '0;
      last_link_q  <= 1'b0;
    end else if (in_fire) begin
      mode_q       <= mode_d;
      elapsed_q    <= elapsed_d;
      backoff_q    <= backoff_d;
      timeouts_q   <= timeouts_d;
      cur_index_q  <= cur_index_d;
      scanning_q   <= scanning_d;
      best_valid_q <= best_valid_d;
      best_index_q <= best_index_d;
      best_level_q <= best_level_d;
      last_link_q  <= last_link_d;
    end
  end

  // output register: fill on accept, drain when the consumer takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_state_q <= mode_d;
      res_cmd_q   <= res_cmd_d;
      res_index_q <= res_index_d;
      res_retry_q <= timeouts_d;
      res_conn_q  <= (mode_d == lrbs_pkg::MODE_UP) & last_link_d;
      res_ind_q   <= res_ind_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign fsm_state_o     = res_state_q;
  assign command_o       = res_cmd_q;
  assign connect_index_o = res_index_q;
  assign retry_count_o   = res_retry_q;
  assign connected_o     = res_conn_q;
  assign indicator_o     = res_ind_q;

endmodule
`default_nettype wire

>>> bench/tb_link_reconnect_backoff_supervisor.sv
`timescale 1ns / 100ps

module tb_link_reconnect_backoff_supervisor;

  // Quiet cycles (no transfer on any channel) before the run is declared hung
  localparam int unsigned HANG_LIMIT = 2000;

  // One result transfer of the supervisor
  typedef struct packed {
    logic [2:0] fsm_state;
    logic [1:0] command;
    logic [3:0] connect_index;
    logic [3:0] retry_count;
    logic       connected;
    logic [1:0] indicator;
  } status_t;

  // Tracks the supervisor's mode, timer and backoff from the accepted events
  // and queues the status every event must produce.
  class reconnect_tracker;
    // register copies
    logic [15:0] timeout_ms;
    logic [3:0]  retry_limit;
    logic [15:0] base_ms;
    logic [15:0] cap_ms;
    logic [15:0] drop_ms;
    logic [4:0]  known_count;
    // supervisor state
    logic [2:0]        mode;
    logic [15:0]       elapsed;
    int unsigned       backoff;
    logic [3:0]        timeouts;
    logic [3:0]        current_net;
    logic              scanning;
    logic              have_best;
    logic [3:0]        best_net;
    logic signed [7:0] best_level;
    logic              link_seen;
    status_t           awaited_status[$];
    int unsigned       error_count;

    function new();
      timeout_ms  = lrbs_pkg::RST_CONNECT_TIMEOUT;
      retry_limit = lrbs_pkg::RST_RETRY_LIMIT;
      base_ms     = lrbs_pkg::RST_BASE_DELAY;
      cap_ms      = lrbs_pkg::RST_MAX_DELAY;
      drop_ms     = lrbs_pkg::RST_DROP_DELAY;
      known_count = lrbs_pkg::RST_KNOWN_COUNT;
      mode        = lrbs_pkg::MODE_IDLE;
      elapsed     = '0;
      backoff     = lrbs_pkg::RST_BASE_DELAY;
      timeouts    = '0;
      current_net = '0;
      scanning    = 1'b0;
      have_best   = 1'b0;
      best_net    = '0;
      best_level  = '0;
      link_seen   = 1'b0;
      error_count = 0;
    endfunction

    function void apply_setting(logic [2:0] idx, logic [15:0] data);
      case (idx)
        lrbs_pkg::REG_CONNECT_TIMEOUT: timeout_ms  = data;
        lrbs_pkg::REG_RETRY_LIMIT:     retry_limit = data[3:0];
        lrbs_pkg::REG_BASE_DELAY:      base_ms     = data;
        lrbs_pkg::REG_MAX_DELAY:       cap_ms      = data;
        lrbs_pkg::REG_DROP_DELAY:      drop_ms     = data;
        lrbs_pkg::REG_KNOWN_COUNT:     known_count = data[4:0];
        default: ;
      endcase
    endfunction

    function int unsigned known_limit();
      return (known_count < lrbs_pkg::MAX_KNOWN) ? known_count : lrbs_pkg::MAX_KNOWN;
    endfunction

    // Any change of mode restarts the timer
    function void switch_mode(logic [2:0] m);
      mode    = m;
      elapsed = '0;
    endfunction

    function void double_backoff();
      int unsigned twice;
      twice   = backoff * 2;
      backoff = (twice < cap_ms) ? twice : cap_ms;
    endfunction

    function void note_event(logic [1:0] req, logic link, logic match, logic [3:0] net,
                             logic signed [7:0] rssi);
      status_t    exp_status;
      logic [1:0] cmd;
      logic [1:0] ind;
      logic       connect_now;
      cmd         = lrbs_pkg::CMD_NONE;
      ind         = lrbs_pkg::IND_NONE;
      connect_now = 1'b0;
      case (req)
        lrbs_pkg::REQ_TICK: begin
          if (elapsed != lrbs_pkg::TICKS_MAX) elapsed = elapsed + 16'd1;
          link_seen = link;
          case (mode)
            lrbs_pkg::MODE_SCAN: begin
              // first tick of a fresh scan launches it
              if (!scanning) begin
                scanning  = 1'b1;
                have_best = 1'b0;
                cmd       = lrbs_pkg::CMD_SCAN;
              end
            end
            lrbs_pkg::MODE_CONN: begin
              if (link) begin
                switch_mode(lrbs_pkg::MODE_UP);
                timeouts = '0;
                backoff  = base_ms;
                ind      = lrbs_pkg::IND_ON;
              end else if (elapsed > timeout_ms) begin
                cmd      = lrbs_pkg::CMD_DROP;
                timeouts = timeouts + 4'd1;
                if (timeouts >= retry_limit) begin
                  timeouts = '0;
                  backoff  = base_ms;
                  switch_mode(lrbs_pkg::MODE_SCAN);
                  scanning = 1'b0;
                end else begin
                  switch_mode(lrbs_pkg::MODE_RETRY);
                  double_backoff();
                end
              end
            end
            lrbs_pkg::MODE_UP: begin
              if (!link) begin
                ind      = lrbs_pkg::IND_OFF;
                timeouts = '0;
                backoff  = drop_ms;
                switch_mode(lrbs_pkg::MODE_RETRY);
              end
            end
            lrbs_pkg::MODE_RETRY: begin
              if (elapsed >= backoff) begin
                switch_mode(lrbs_pkg::MODE_SCAN);
                scanning = 1'b0;
              end
            end
            default: ;
          endcase
        end
        lrbs_pkg::REQ_SCAN_ENT: begin
          // strongest match wins, the earlier entry on a tie
          if (mode == lrbs_pkg::MODE_SCAN && scanning && match && net < known_limit()) begin
            if (!have_best || rssi > best_level) begin
              have_best  = 1'b1;
              best_net   = net;
              best_level = rssi;
            end
          end
        end
        lrbs_pkg::REQ_SCAN_END: begin
          if (mode == lrbs_pkg::MODE_SCAN && scanning) begin
            scanning = 1'b0;
            if (have_best) begin
              if (best_net < known_limit()) begin
                current_net = best_net;
                switch_mode(lrbs_pkg::MODE_CONN);
                cmd         = lrbs_pkg::CMD_CONNECT;
                connect_now = 1'b1;
              end else begin
                switch_mode(lrbs_pkg::MODE_IDLE);
              end
            end else begin
              switch_mode(lrbs_pkg::MODE_RETRY);
              double_backoff();
            end
            have_best = 1'b0;
          end
        end
        default: begin
          cmd = lrbs_pkg::CMD_DROP;
          switch_mode(lrbs_pkg::MODE_SCAN);
          scanning  = 1'b0;
          have_best = 1'b0;
          timeouts  = '0;
          backoff   = base_ms;
        end
      endcase
      exp_status.fsm_state     = mode;
      exp_status.command       = cmd;
      exp_status.connect_index = connect_now ? best_net : current_net;
      exp_status.retry_count   = timeouts;
      exp_status.connected     = (mode == lrbs_pkg::MODE_UP) && link_seen;
      exp_status.indicator     = ind;
      awaited_status.push_back(exp_status);
    endfunction

    function void check_status(status_t got);
      status_t want;
      if (awaited_status.size() == 0) begin
        $error("status transfer with nothing awaited: state %0d command %0d",
               got.fsm_state, got.command);
        error_count++;
        return;
      end
      want = awaited_status.pop_front();
      if (got.fsm_state !== want.fsm_state) begin
        $error("fsm_state: expected %0d, actual %0d", want.fsm_state, got.fsm_state);
        error_count++;
      end
      if (got.command !== want.command) begin
        $error("command: expected %0d, actual %0d", want.command, got.command);
        error_count++;
      end
      if (got.connect_index !== want.connect_index) begin
        $error("connect_index: expected %0d, actual %0d", want.connect_index,
               got.connect_index);
        error_count++;
      end
      if (got.retry_count !== want.retry_count) begin
        $error("retry_count: expected %0d, actual %0d", want.retry_count, got.retry_count);
        error_count++;
      end
      if (got.connected !== want.connected) begin
        $error("connected: expected %0d, actual %0d", want.connected, got.connected);
        error_count++;
      end
      if (got.indicator !== want.indicator) begin
        $error("indicator: expected %0d, actual %0d", want.indicator, got.indicator);
        error_count++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [2:0]        cfg_index_i;
  logic [15:0]       cfg_data_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        req_type_i;
  logic              link_up_i;
  logic              scan_match_i;
  logic [3:0]        scan_known_index_i;
  logic signed [7:0] scan_rssi_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [2:0]        fsm_state_o;
  logic [1:0]        command_o;
  logic [3:0]        connect_index_o;
  logic [3:0]        retry_count_o;
  logic              connected_o;
  logic [1:0]        indicator_o;

  reconnect_tracker tracker;
  status_t          seen_status;
  int unsigned      gap_pct;     // chance in percent that the sender holds off a cycle
  int unsigned      stall_pct;   // chance in percent that the receiver stalls a cycle
  int unsigned      cur_known;   // known_count as last written, steers scan indexes
  int unsigned      quiet_cycles;

  link_reconnect_backoff_supervisor dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .req_type_i         (req_type_i),
    .link_up_i          (link_up_i),
    .scan_match_i       (scan_match_i),
    .scan_known_index_i (scan_known_index_i),
    .scan_rssi_i        (scan_rssi_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .fsm_state_o        (fsm_state_o),
    .command_o          (command_o),
    .connect_index_o    (connect_index_o),
    .retry_count_o      (retry_count_o),
    .connected_o        (connected_o),
    .indicator_o        (indicator_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Receiver side: stall at random with the current pressure
  always @(posedge clk_i) begin
    out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Observe both channels at every edge. Inputs and outputs are driven with
  // nonblocking updates, so the values seen here are the ones the edge sampled.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        tracker.note_event(req_type_i, link_up_i, scan_match_i, scan_known_index_i,
                           scan_rssi_i);
      end
      if (out_valid_o && !out_stall_i) begin
        seen_status = '{fsm_state: fsm_state_o, command: command_o,
                        connect_index: connect_index_o, retry_count: retry_count_o,
                        connected: connected_o, indicator: indicator_o};
        tracker.check_status(seen_status);
      end
      // Watchdog: give up after a long stretch with no transfer anywhere
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= HANG_LIMIT) begin
        $display("tb_link_reconnect_backoff_supervisor: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Present one event and hold it until the transfer happens. Valid is left
  // high on return so a back-to-back event keeps it asserted.
  task automatic send_event(input logic [1:0] req, input logic link, input logic match,
                            input logic [3:0] net, input logic [7:0] rssi);
    while ((gap_pct != 0) && ($urandom_range(99) < gap_pct)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    req_type_i         <= req;
    link_up_i          <= link;
    scan_match_i       <= match;
    scan_known_index_i <= net;
    scan_rssi_i        <= rssi;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Drop valid and wait until every awaited status has come back, then let
  // the output register settle. The first edge lets the last accepted
  // event reach the tracker before its queue is looked at.
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.awaited_status.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Write all six registers in index order; only called with nothing in flight
  task automatic load_settings(input int unsigned tmo, input int unsigned lim,
                               input int unsigned base, input int unsigned cap,
                               input int unsigned drop, input int unsigned known);
    logic [2:0]  regs [6] = '{lrbs_pkg::REG_CONNECT_TIMEOUT, lrbs_pkg::REG_RETRY_LIMIT,
                               lrbs_pkg::REG_BASE_DELAY, lrbs_pkg::REG_MAX_DELAY,
                               lrbs_pkg::REG_DROP_DELAY, lrbs_pkg::REG_KNOWN_COUNT};
    int unsigned vals [6];
    vals = '{tmo, lim, base, cap, drop, known};
    for (int i = 0; i < 6; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_data_i  <= 16'(vals[i]);
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      tracker.apply_setting(regs[i], 16'(vals[i]));
    end
    cfg_valid_i <= 1'b0;
    cur_known = known;
  endtask

  // Mostly well-formed traffic: scan episodes with random entries, runs of
  // ticks with steady or flapping link status, and some raw noise.
  task automatic random_traffic(input int unsigned n);
    int unsigned sent;
    int unsigned kind;
    int unsigned len;
    int unsigned pattern;
    int unsigned lim;
    logic [3:0]  net;
    logic [7:0]  rssi;
    sent = 0;
    lim  = (cur_known < lrbs_pkg::MAX_KNOWN) ? cur_known : lrbs_pkg::MAX_KNOWN;
    while (sent < n) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        if ($urandom_range(1) == 1) begin
          send_event(lrbs_pkg::REQ_RECONNECT, 1'($urandom), 1'($urandom), 4'($urandom),
                     8'($urandom));
          sent++;
        end
        send_event(lrbs_pkg::REQ_TICK, 1'($urandom), 1'($urandom), 4'($urandom),
                   8'($urandom));
        len = $urandom_range(6);
        repeat (len) begin
          net = (lim == 0 || $urandom_range(4) == 0) ? 4'($urandom_range(15))
                                                      : 4'($urandom_range(lim - 1));
          case ($urandom_range(2))
            0:       rssi = 8'($urandom);
            1:       rssi = ($urandom_range(1) == 1) ? 8'h80 : 8'h7f;
            default: rssi = 8'(-60 + 10 * $urandom_range(2));  // ties likely
          endcase
          send_event(lrbs_pkg::REQ_SCAN_ENT, 1'($urandom), $urandom_range(9) != 0, net,
                     rssi);
        end
        send_event(lrbs_pkg::REQ_SCAN_END, 1'($urandom), 1'($urandom), 4'($urandom),
                   8'($urandom));
        sent += len + 2;
      end else if (kind < 80) begin
        len     = $urandom_range(1, 40);
        pattern = $urandom_range(2);
        repeat (len) begin
          send_event(lrbs_pkg::REQ_TICK, (pattern == 2) ? 1'($urandom) : 1'(pattern),
                     1'($urandom), 4'($urandom), 8'($urandom));
        end
        sent += len;
      end else begin
        send_event(2'($urandom), 1'($urandom), 1'($urandom), 4'($urandom), 8'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    tracker            = new();
    rst_ni             = 1'b0;
    cfg_valid_i        = 1'b0;
    cfg_index_i        = '0;
    cfg_data_i         = '0;
    in_valid_i         = 1'b0;
    req_type_i         = lrbs_pkg::REQ_TICK;
    link_up_i          = 1'b0;
    scan_match_i       = 1'b0;
    scan_known_index_i = '0;
    scan_rssi_i        = '0;
    out_stall_i        = 1'b0;
    gap_pct            = 0;
    stall_pct          = 0;
    cur_known          = lrbs_pkg::RST_KNOWN_COUNT;
    quiet_cycles       = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: no known network, so the scan finds nothing and backs off
    send_event(lrbs_pkg::REQ_SCAN_END, 1'b0, 1'b0, 4'd0, 8'd0);
    send_event(lrbs_pkg::REQ_RECONNECT, 1'b0, 1'b0, 4'd0, 8'd0);
    send_event(lrbs_pkg::REQ_TICK, 1'b1, 1'b0, 4'd0, 8'd0);
    send_event(lrbs_pkg::REQ_SCAN_ENT, 1'b0, 1'b1, 4'd0, 8'd50);
    send_event(lrbs_pkg::REQ_SCAN_END, 1'b0, 1'b0, 4'd0, 8'd0);
    send_event(lrbs_pkg::REQ_TICK, 1'b0, 1'b0, 4'd0, 8'd0);
    wait_quiet();

    // Short delays so every path is reachable within a handful of ticks
    load_settings(3, 2, 1, 5, 2, 16);
    send_event(lrbs_pkg::REQ_RECONNECT, 1'b0, 1'b0, 4'd0, 8'd0);
    send_event(lrbs_pkg::REQ_SCAN_ENT, 1'b0, 1'b1, 4'd1, 8'd10);    // no scan running yet
    send_event(lrbs_pkg::REQ_TICK, 1'b0, 1'b0, 4'd0, 8'd0);
    send_event(lrbs_pkg::REQ_SCAN_ENT, 1'b0, 1'b1, 4'd3, 8'h80);
    send_event(lrbs_pkg::REQ_SCAN_ENT, 1'b0, 1'b1, 4'd5, 8'h80);    // equal, keep first
    send_event(lrbs_pkg::REQ_SCAN_ENT, 1'b0, 1'b0, 4'd7, 8'h7f);    // not a known network
    send_event(lrbs_pkg::REQ_SCAN_ENT, 1'b0, 1'b1, 4'd15, 8'h7f);
    send_event(lrbs_pkg::REQ_SCAN_ENT, 1'b0, 1'b1, 4'd2, 8'h7f);    // equal, keep first
    send_event(lrbs_pkg::REQ_SCAN_END, 1'b0, 1'b0, 4'd0, 8'd0);
    send_event(lrbs_pkg::REQ_TICK, 1'b1, 1'b0, 4'd0, 8'd0);         // associated
    send_event(lrbs_pkg::REQ_TICK, 1'b0, 1'b0, 4'd0, 8'd0);         // link lost
    repeat (2) send_event(lrbs_pkg::REQ_TICK, 1'b0, 1'b0, 4'd0, 8'd0);
    send_event(lrbs_pkg::REQ_TICK, 1'b0, 1'b0, 4'd0, 8'd0);
    send_event(lrbs_pkg::REQ_SCAN_END, 1'b0, 1'b0, 4'd0, 8'd0);     // empty scan
    send_event(lrbs_pkg::REQ_RECONNECT, 1'b1, 1'b1, 4'd9, 8'd1);
    send_event(lrbs_pkg::REQ_TICK, 1'b0, 1'b0, 4'd0, 8'd0);
    send_event(lrbs_pkg::REQ_SCAN_ENT, 1'b0, 1'b1, 4'd0, 8'd0);
    send_event(lrbs_pkg::REQ_SCAN_END, 1'b0, 1'b0, 4'd0, 8'd0);
    repeat (6) send_event(lrbs_pkg::REQ_TICK, 1'b0, 1'b0, 4'd0, 8'd0);  // connect timeout
    wait_quiet();

    // Light sender gaps, heavy receiver stalls
    gap_pct   = 17;
    stall_pct = 75;
    load_settings(5, 3, 2, 12, 3, 16);
    random_traffic(360);
    // Leave a scan open with a high index, then shrink the known list under it
    send_event(lrbs_pkg::REQ_RECONNECT, 1'b0, 1'b0, 4'd0, 8'd0);
    send_event(lrbs_pkg::REQ_TICK, 1'b0, 1'b0, 4'd0, 8'd0);
    send_event(lrbs_pkg::REQ_SCAN_ENT, 1'b0, 1'b1, 4'd12, 8'd5);
    wait_quiet();
    load_settings(0, 1, 0, 0, 0, 1);
    send_event(lrbs_pkg::REQ_SCAN_END, 1'b0, 1'b0, 4'd0, 8'd0);
    random_traffic(220);
    wait_quiet();

    // Heavy sender gaps, light receiver stalls
    gap_pct   = 75;
    stall_pct = 17;
    load_settings(8, 15, 1, 65535, 7, 8);
    random_traffic(360);
    wait_quiet();
    load_settings(2, 0, 3, 9, 1, 31);
    random_traffic(220);
    wait_quiet();

    // No idling at all
    gap_pct   = 0;
    stall_pct = 0;
    load_settings($urandom_range(12), $urandom_range(15), $urandom_range(6),
                  $urandom_range(40), $urandom_range(10), $urandom_range(16));
    random_traffic(220);
    wait_quiet();

    // Largest delays: a connect that never times out, then a doubled backoff
    // that must cap at the top of the range rather than wrap
    load_settings(65535, 15, 65535, 65535, 65535, 16);
    send_event(lrbs_pkg::REQ_RECONNECT, 1'b0, 1'b0, 4'd0, 8'd0);
    send_event(lrbs_pkg::REQ_TICK, 1'b0, 1'b0, 4'd0, 8'd0);
    send_event(lrbs_pkg::REQ_SCAN_ENT, 1'b0, 1'b1, 4'd9, 8'hff);
    send_event(lrbs_pkg::REQ_SCAN_END, 1'b0, 1'b0, 4'd0, 8'd0);
    repeat (40) send_event(lrbs_pkg::REQ_TICK, 1'b0, 1'b0, 4'd0, 8'd0);
    send_event(lrbs_pkg::REQ_RECONNECT, 1'b0, 1'b0, 4'd0, 8'd0);
    send_event(lrbs_pkg::REQ_TICK, 1'b0, 1'b0, 4'd0, 8'd0);
    send_event(lrbs_pkg::REQ_SCAN_END, 1'b0, 1'b0, 4'd0, 8'd0);
    repeat (40) send_event(lrbs_pkg::REQ_TICK, 1'($urandom), 1'b0, 4'd0, 8'd0);
    send_event(lrbs_pkg::REQ_SCAN_END, 1'b0, 1'b0, 4'd0, 8'd0);
    wait_quiet();

    if (tracker.error_count == 0) begin
      $display("tb_link_reconnect_backoff_supervisor: clean");
    end else begin
      $display("tb_link_reconnect_backoff_supervisor: errors");
    end
    $finish;
  end

endmodule

>>> link_reconnect_backoff_supervisor.f
sv/lrbs_pkg.sv
sv/link_reconnect_backoff_supervisor.sv
bench/tb_link_reconnect_backoff_supervisor.sv
